@@ sv/sibling_link_table_core_macros.svh @@
// Assertion macros for the sibling link table core.
// Included by sibling_link_table_core.sv, the RTL file that carries concurrent assertions; no other dependencies.
`ifndef SIBLING_LINK_TABLE_CORE_MACROS_SVH
`define SIBLING_LINK_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SLT_ASSERT(lbl, clk, rstn, prop, msg)
`define SLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ sv/slt_pkg.sv @@
// Shared types, constants and the microcode ROM of the sibling link table core.
// Has no dependencies; used by every other RTL file.
`default_nettype none

package slt_pkg;

  localparam int SLT_DEPTH = 64;
  localparam int FUNC_W    = 3;
  localparam int IN_STMT_W = 10;
  localparam int STMT_W    = 11;
  localparam int UPC_W     = 4;

  localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_NBR   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LIST  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DTEST = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CTEST = 3'd4;

  localparam logic [UPC_W-1:0] U_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] U_DISP  = 4'd1;
  localparam logic [UPC_W-1:0] U_ERR   = 4'd2;
  localparam logic [UPC_W-1:0] U_SET   = 4'd3;
  localparam logic [UPC_W-1:0] U_NRD   = 4'd4;
  localparam logic [UPC_W-1:0] U_NEM   = 4'd5;
  localparam logic [UPC_W-1:0] U_LRD0  = 4'd6;
  localparam logic [UPC_W-1:0] U_LCHK  = 4'd7;
  localparam logic [UPC_W-1:0] U_LNONE = 4'd8;
  localparam logic [UPC_W-1:0] U_LRD   = 4'd9;
  localparam logic [UPC_W-1:0] U_LEM   = 4'd10;
  localparam logic [UPC_W-1:0] U_TRD   = 4'd11;
  localparam logic [UPC_W-1:0] U_TEM   = 4'd12;
  localparam logic [UPC_W-1:0] U_CRD   = 4'd13;
  localparam logic [UPC_W-1:0] U_CEM   = 4'd14;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [IN_STMT_W-1:0] first_stmt;
    logic [IN_STMT_W-1:0] second_stmt;
    logic                 direction;
  } slt_in_t;

  typedef struct packed {
    logic signed [STMT_W-1:0] stmt_out;
    logic                     is_true;
    logic                     status;
    logic                     last;
  } slt_out_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_WAIT,
    C_DISP,
    C_LINK_VALID,
    C_LIST_MORE,
    C_CHAIN_MORE
  } slt_cond_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_ALWAYS,
    EM_NOT_TAKEN
  } slt_emit_e;

  typedef enum logic [1:0] {
    SS_NONE,
    SS_LINK,
    SS_CUR
  } slt_sel_e;

  typedef struct packed {
    slt_cond_e        cond;
    logic [UPC_W-1:0] target;
    logic             fall_idle;
    logic             rd;
    logic             wr;
    slt_emit_e        emit_mode;
    slt_sel_e         stmt_sel;
    logic             t_eq;
    logic             status;
    logic             last_end;
    logic             ld_cur;
    logic             inc_cnt;
  } slt_uword_t;

  typedef struct packed {
    logic             accept;
    logic             link_vld;
    logic             list_more;
    logic             chain_more;
    logic [UPC_W-1:0] disp_pc;
  } slt_flags_t;

  typedef struct packed {
    logic     rd;
    logic     wr;
    logic     emit;
    slt_sel_e stmt_sel;
    logic     t_eq;
    logic     status;
    logic     last_end;
    logic     ld_cur;
    logic     inc_cnt;
  } slt_ctl_t;

  function automatic slt_uword_t slt_urom(input logic [UPC_W-1:0] pc);
    slt_uword_t w;
    w = '0;
    unique case (pc)
      U_IDLE: begin
        w.cond   = C_WAIT;
        w.target = U_IDLE;
      end
      U_DISP: begin
        w.cond = C_DISP;
      end
      U_ERR: begin
        w.emit_mode = EM_ALWAYS;
        w.status    = 1'b1;
        w.cond      = C_ALWAYS;
        w.target    = U_IDLE;
      end
      U_SET: begin
        w.wr        = 1'b1;
        w.emit_mode = EM_ALWAYS;
        w.cond      = C_ALWAYS;
        w.target    = U_IDLE;
      end
      U_NRD: begin
        w.rd = 1'b1;
      end
      U_NEM: begin
        w.emit_mode = EM_ALWAYS;
        w.stmt_sel  = SS_LINK;
        w.cond      = C_ALWAYS;
        w.target    = U_IDLE;
      end
      U_LRD0: begin
        w.rd = 1'b1;
      end
      U_LCHK: begin
        w.ld_cur = 1'b1;
        w.cond   = C_LINK_VALID;
        w.target = U_LRD;
      end
      U_LNONE: begin
        w.emit_mode = EM_ALWAYS;
        w.cond      = C_ALWAYS;
        w.target    = U_IDLE;
      end
      U_LRD: begin
        w.rd = 1'b1;
      end
      U_LEM: begin
        w.emit_mode = EM_ALWAYS;
        w.stmt_sel  = SS_CUR;
        w.last_end  = 1'b1;
        w.ld_cur    = 1'b1;
        w.inc_cnt   = 1'b1;
        w.cond      = C_LIST_MORE;
        w.target    = U_LRD;
        w.fall_idle = 1'b1;
      end
      U_TRD: begin
        w.rd = 1'b1;
      end
      U_TEM: begin
        w.emit_mode = EM_ALWAYS;
        w.t_eq      = 1'b1;
        w.cond      = C_ALWAYS;
        w.target    = U_IDLE;
      end
      U_CRD: begin
        w.rd = 1'b1;
      end
      U_CEM: begin
        w.emit_mode = EM_NOT_TAKEN;
        w.t_eq      = 1'b1;
        w.ld_cur    = 1'b1;
        w.inc_cnt   = 1'b1;
        w.cond      = C_CHAIN_MORE;
        w.target    = U_CRD;
        w.fall_idle = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/slt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Uses slt_pkg for its default depth only.
`default_nettype none

module slt_ram
  import slt_pkg::*;
#(
  parameter int Width = 6,
  parameter int Depth = SLT_DEPTH,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/slt_useq.sv @@
// Microcode sequencer: step counter, control ROM from slt_pkg and jump logic.
// Depends on slt_pkg; drives the datapath of sibling_link_table_core.
`default_nettype none

module slt_useq
  import slt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire slt_flags_t flags_i,
  output slt_ctl_t        ctl_o,
  output logic            busy_o
);

  logic [UPC_W-1:0] pc_q, pc_d;
  slt_uword_t       uw;
  logic             taken;

  always_comb begin
    uw = slt_urom(pc_q);
    unique case (uw.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_WAIT:       taken = !flags_i.accept;
      C_DISP:       taken = 1'b1;
      C_LINK_VALID: taken = flags_i.link_vld;
      C_LIST_MORE:  taken = flags_i.list_more;
      C_CHAIN_MORE: taken = flags_i.chain_more;
      default:      taken = 1'b0;
    endcase

    priority if (taken && uw.cond == C_DISP) begin
      pc_d = flags_i.disp_pc;
    end else if (taken) begin
      pc_d = uw.target;
    end else if (uw.fall_idle) begin
      pc_d = U_IDLE;
    end else begin
      pc_d = pc_q + 1'b1;
    end

    ctl_o.rd       = uw.rd;
    ctl_o.wr       = uw.wr;
    ctl_o.emit     = (uw.emit_mode == EM_ALWAYS) ||
                     ((uw.emit_mode == EM_NOT_TAKEN) && !taken);
    ctl_o.stmt_sel = uw.stmt_sel;
    ctl_o.t_eq     = uw.t_eq;
    ctl_o.status   = uw.status;
    ctl_o.last_end = uw.last_end;
    ctl_o.ld_cur   = uw.ld_cur;
    ctl_o.inc_cnt  = uw.inc_cnt;
  end

  assign busy_o = (pc_q != U_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= U_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/sibling_link_table_core.sv @@
// Each item is accepted only while busy is low and is finished before the next one is
// taken. A set, error or unused-code item gives its one result without a link read;
// neighbour and direct test give it after one link read. A chain list gives its members
// one per link read, and a chain test answers after one or more link reads. The link
// reads from the link RAMs set the pace of an item. The receiver cannot stall.
// Reset clears the per-entry valid bits at once, so every link reads as none right away.
`default_nettype none
`include "sibling_link_table_core_macros.svh"

module sibling_link_table_core
  import slt_pkg::*;
#(
  parameter int DEPTH = SLT_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  input  wire slt_in_t cmd_i,
  output logic         busy,
  output logic         result_valid_o,
  output slt_out_t     result_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  slt_flags_t flags;
  slt_ctl_t   ctl;

  logic [FUNC_W-1:0] func_q;
  logic [IdxW-1:0]   a_q, b_q, cur_q, cnt_q;
  logic              a_ok_q, b_ok_q, tbl_q, link_vld_q;
  logic [DEPTH-1:0]  next_vld_q, prev_vld_q;
  logic [IdxW-1:0]   next_rdata, prev_rdata, link_idx;
  logic              accept, link_eq, cnt_end;
  slt_out_t          res_d;

  assign accept   = start && !busy;
  assign link_idx = tbl_q ? next_rdata : prev_rdata;
  assign link_eq  = link_vld_q && (link_idx == b_q);
  assign cnt_end  = (cnt_q == IdxW'(DEPTH - 1));

  slt_useq u_seq (
    .clk_i,
    .rst_ni,
    .flags_i (flags),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  slt_ram #(.Width(IdxW), .Depth(DEPTH)) u_next_ram (
    .clk_i,
    .we_i    (ctl.wr),
    .waddr_i (a_q),
    .wdata_i (b_q),
    .re_i    (ctl.rd),
    .raddr_i (cur_q),
    .rdata_o (next_rdata)
  );

  slt_ram #(.Width(IdxW), .Depth(DEPTH)) u_prev_ram (
    .clk_i,
    .we_i    (ctl.wr),
    .waddr_i (b_q),
    .wdata_i (a_q),
    .re_i    (ctl.rd),
    .raddr_i (cur_q),
    .rdata_o (prev_rdata)
  );

  always_comb begin
    flags.accept     = accept;
    flags.link_vld   = link_vld_q;
    flags.list_more  = link_vld_q && !cnt_end;
    flags.chain_more = link_vld_q && !link_eq && !cnt_end;

    priority if (func_q > FUNC_CTEST || !a_ok_q) begin
      flags.disp_pc = U_ERR;
    end else if (!b_ok_q && (func_q == FUNC_SET || func_q == FUNC_DTEST ||
                             func_q == FUNC_CTEST)) begin
      flags.disp_pc = U_ERR;
    end else begin
      unique case (func_q)
        FUNC_SET:   flags.disp_pc = U_SET;
        FUNC_NBR:   flags.disp_pc = U_NRD;
        FUNC_LIST:  flags.disp_pc = U_LRD0;
        FUNC_DTEST: flags.disp_pc = U_TRD;
        default:    flags.disp_pc = U_CRD;
      endcase
    end
  end

  always_comb begin
    unique case (ctl.stmt_sel)
      SS_LINK: res_d.stmt_out = link_vld_q ?
                 $signed({{(STMT_W - IdxW){1'b0}}, link_idx}) : '1;
      SS_CUR:  res_d.stmt_out = $signed({{(STMT_W - IdxW){1'b0}}, cur_q});
      default: res_d.stmt_out = '1;
    endcase
    res_d.is_true = ctl.t_eq && link_eq;
    res_d.status  = ctl.status;
    res_d.last    = ctl.last_end ? !flags.list_more : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vld_q     <= '0;
      prev_vld_q     <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= ctl.emit;
      if (ctl.wr) begin
        next_vld_q[a_q] <= 1'b1;
        prev_vld_q[b_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= cmd_i.func;
      a_q    <= cmd_i.first_stmt[IdxW-1:0];
      cur_q  <= cmd_i.first_stmt[IdxW-1:0];
      b_q    <= cmd_i.second_stmt[IdxW-1:0];
      a_ok_q <= cmd_i.first_stmt < IN_STMT_W'(DEPTH);
      b_ok_q <= cmd_i.second_stmt < IN_STMT_W'(DEPTH);
      tbl_q  <= cmd_i.direction || cmd_i.func == FUNC_DTEST || cmd_i.func == FUNC_CTEST;
      cnt_q  <= '0;
    end else begin
      if (ctl.ld_cur) begin
        cur_q <= link_idx;
      end
      if (ctl.inc_cnt) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
    if (ctl.rd) begin
      link_vld_q <= tbl_q ? next_vld_q[cur_q] : prev_vld_q[cur_q];
    end
    if (ctl.emit) begin
      result_o <= res_d;
    end
  end

  `SLT_ASSERT(a_result_while_busy, clk_i, rst_ni, result_valid_o |-> $past(busy), "result without a pending item")
  `SLT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy, "accepted item did not start work")
  `SLT_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, result_valid_o && result_o.last, !result_valid_o, "result after the last one of an item")
  `SLT_ASSERT_NEXT(a_more_follows, clk_i, rst_ni, result_valid_o && !result_o.last, busy, "item ended before its last result")
  `SLT_ASSERT(a_error_single, clk_i, rst_ni, (result_valid_o && result_o.status) |-> result_o.last, "error result not marked last")

endmodule

`default_nettype wire

@@ sim/sibling_link_table_core_tb.sv @@
// Self-checking testbench for sibling_link_table_core: a directed table, then random items.
// Results are checked against typed rows or a link-table predictor; depends only on slt_pkg and the core.
module sibling_link_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slt_pkg::*;

  localparam int TBL_DEPTH = SLT_DEPTH;
  localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
  localparam int ITEMS_PER_PHASE = 67;

  typedef struct {
    slt_in_t  cmd;
    bit       typed;
    slt_out_t res;
  } row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  slt_in_t  cmd_i = '0;
  logic     busy;
  logic     result_valid_o;
  slt_out_t result_o;

  logic signed [6:0] next_tbl [TBL_DEPTH];
  logic signed [6:0] prev_tbl [TBL_DEPTH];
  slt_out_t step_res [$];
  slt_out_t pending [$];
  row_t     rows [$];
  int       err_cnt = 0;

  sibling_link_table_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic slt_out_t outcome(int s, bit t, bit st, bit l);
    slt_out_t r;
    r.stmt_out = s[STMT_W-1:0];
    r.is_true  = t;
    r.status   = st;
    r.last     = l;
    return r;
  endfunction

  function automatic void queue_res(slt_out_t r);
    step_res = {step_res, r};
  endfunction

  function automatic slt_in_t mk_cmd(logic [FUNC_W-1:0] f, int a, int b, bit dir);
    slt_in_t c;
    c.func        = f;
    c.first_stmt  = a[IN_STMT_W-1:0];
    c.second_stmt = b[IN_STMT_W-1:0];
    c.direction   = dir;
    return c;
  endfunction

  function automatic int link_at(bit dir, int idx);
    if (idx < 0 || idx >= TBL_DEPTH) return -1;
    return dir ? int'(next_tbl[idx]) : int'(prev_tbl[idx]);
  endfunction

  task automatic predict_links(input slt_in_t c);
    int a, b, s, n;
    bit a_ok, b_ok, hit;
    slt_out_t r;
    a = int'(c.first_stmt);
    b = int'(c.second_stmt);
    a_ok = a < TBL_DEPTH;
    b_ok = b < TBL_DEPTH;
    step_res.delete();
    case (c.func)
      FUNC_SET: begin
        if (!a_ok || !b_ok) begin
          queue_res(outcome(-1, 1'b0, 1'b1, 1'b1));
        end else begin
          next_tbl[a] = b[6:0];
          prev_tbl[b] = a[6:0];
          queue_res(outcome(-1, 1'b0, 1'b0, 1'b1));
        end
      end
      FUNC_NBR: begin
        if (!a_ok) queue_res(outcome(-1, 1'b0, 1'b1, 1'b1));
        else queue_res(outcome(link_at(c.direction, a), 1'b0, 1'b0, 1'b1));
      end
      FUNC_LIST: begin
        if (!a_ok) begin
          queue_res(outcome(-1, 1'b0, 1'b1, 1'b1));
        end else begin
          s = link_at(c.direction, a);
          if (s < 0) begin
            queue_res(outcome(-1, 1'b0, 1'b0, 1'b1));
          end else begin
            n = 0;
            while (s >= 0 && n < TBL_DEPTH) begin
              r = outcome(s, 1'b0, 1'b0, 1'b0);
              n++;
              s = link_at(c.direction, s);
              if (!(s >= 0 && n < TBL_DEPTH)) r.last = 1'b1;
              queue_res(r);
            end
          end
        end
      end
      FUNC_DTEST: begin
        if (!a_ok || !b_ok) queue_res(outcome(-1, 1'b0, 1'b1, 1'b1));
        else queue_res(outcome(-1, int'(next_tbl[a]) == b, 1'b0, 1'b1));
      end
      FUNC_CTEST: begin
        if (!a_ok || !b_ok) begin
          queue_res(outcome(-1, 1'b0, 1'b1, 1'b1));
        end else begin
          s = int'(next_tbl[a]);
          hit = 1'b0;
          for (n = 0; n < TBL_DEPTH && s >= 0 && !hit; n++) begin
            if (s == b) hit = 1'b1;
            else s = link_at(1'b1, s);
          end
          queue_res(outcome(-1, hit, 1'b0, 1'b1));
        end
      end
      default: queue_res(outcome(-1, 1'b0, 1'b1, 1'b1));
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic issue(input slt_in_t c, input bit typed, input slt_out_t want);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    predict_links(c);
    if (typed) pending = {pending, want};
    else pending = {pending, step_res};
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain(input int limit);
    int i;
    start <= 1'b0;
    for (i = 0; i < limit && pending.size() != 0; i++) @(posedge clk_i);
  endtask

  function automatic int pick_stmt();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 11);
    if (p < 90) return $urandom_range(0, TBL_DEPTH - 1);
    return $urandom_range(0, 1023);
  endfunction

  function automatic slt_in_t rand_cmd();
    int p;
    logic [FUNC_W-1:0] f;
    p = $urandom_range(0, 99);
    if (p >= 90) return mk_cmd(FUNC_W'($urandom_range(0, 7)), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
    if (p < 28) f = FUNC_SET;
    else if (p < 43) f = FUNC_NBR;
    else if (p < 58) f = FUNC_LIST;
    else if (p < 70) f = FUNC_DTEST;
    else if (p < 85) f = FUNC_CTEST;
    else f = FUNC_W'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
    return mk_cmd(f, pick_stmt(), pick_stmt(), 1'($urandom_range(0, 1)));
  endfunction

  function automatic void add_row(slt_in_t c, bit typed, slt_out_t res);
    row_t r;
    r.cmd   = c;
    r.typed = typed;
    r.res   = res;
    rows = {rows, r};
  endfunction

  always @(posedge clk_i) begin
    slt_out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result %p arrived with nothing expected", result_o));
      end else begin
        want = pending.pop_front();
        if (result_o.stmt_out !== want.stmt_out)
          report_mismatch($sformatf("stmt_out %0d, expected %0d",
                                    result_o.stmt_out, want.stmt_out));
        if (result_o.is_true !== want.is_true)
          report_mismatch($sformatf("is_true %b, expected %b", result_o.is_true, want.is_true));
        if (result_o.status !== want.status)
          report_mismatch($sformatf("status %b, expected %b", result_o.status, want.status));
        if (result_o.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", result_o.last, want.last));
      end
    end
  end

  initial begin
    slt_out_t none_res, err_res, dc;
    int idle_pct, gap;
    none_res = outcome(-1, 1'b0, 1'b0, 1'b1);
    err_res  = outcome(-1, 1'b0, 1'b1, 1'b1);
    dc       = '0;
    foreach (next_tbl[i]) begin
      next_tbl[i] = -7'sd1;
      prev_tbl[i] = -7'sd1;
    end

    add_row(mk_cmd(FUNC_NBR, 0, 0, 1'b1), 1'b1, none_res);
    add_row(mk_cmd(FUNC_LIST, 5, 0, 1'b0), 1'b1, none_res);
    add_row(mk_cmd(FUNC_SET, 1023, 0, 1'b0), 1'b1, err_res);
    add_row(mk_cmd(FUNC_SET, 0, 1023, 1'b1), 1'b1, err_res);
    add_row(mk_cmd(FUNC_SET, 63, 0, 1'b0), 1'b1, none_res);
    add_row(mk_cmd(FUNC_SET, 0, 1, 1'b0), 1'b1, none_res);
    add_row(mk_cmd(FUNC_SET, 1, 2, 1'b1), 1'b1, none_res);
    add_row(mk_cmd(FUNC_SET, 2, 63, 1'b0), 1'b1, none_res);
    add_row(mk_cmd(FUNC_NBR, 0, 0, 1'b1), 1'b0, dc);
    add_row(mk_cmd(FUNC_NBR, 63, 0, 1'b0), 1'b0, dc);
    add_row(mk_cmd(FUNC_NBR, 64, 0, 1'b0), 1'b1, err_res);
    add_row(mk_cmd(FUNC_NBR, 1023, 1023, 1'b1), 1'b1, err_res);
    add_row(mk_cmd(FUNC_LIST, 0, 0, 1'b1), 1'b0, dc);
    add_row(mk_cmd(FUNC_LIST, 63, 0, 1'b0), 1'b0, dc);
    add_row(mk_cmd(FUNC_LIST, 64, 0, 1'b1), 1'b1, err_res);
    add_row(mk_cmd(FUNC_DTEST, 0, 1, 1'b0), 1'b0, dc);
    add_row(mk_cmd(FUNC_DTEST, 64, 0, 1'b0), 1'b1, err_res);
    add_row(mk_cmd(FUNC_DTEST, 0, 1023, 1'b1), 1'b1, err_res);
    add_row(mk_cmd(FUNC_CTEST, 0, 63, 1'b0), 1'b0, dc);
    add_row(mk_cmd(FUNC_CTEST, 1023, 0, 1'b0), 1'b1, err_res);
    add_row(mk_cmd(FUNC_RSVD5, 0, 0, 1'b0), 1'b1, err_res);
    add_row(mk_cmd(FUNC_RSVD6, 1, 2, 1'b1), 1'b1, err_res);
    add_row(mk_cmd(FUNC_RSVD7, 1023, 1023, 1'b1), 1'b1, err_res);
    add_row(mk_cmd(FUNC_SET, 63, 5, 1'b0), 1'b1, none_res);
    add_row(mk_cmd(FUNC_LIST, 0, 0, 1'b1), 1'b0, dc);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) issue(rows[i].cmd, rows[i].typed, rows[i].res);
    drain(2000);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 15 : (phase == 1) ? 82 : 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 6);
          pause(gap);
        end
        issue(rand_cmd(), 1'b0, dc);
      end
      drain(2000);
    end

    drain(4000);
    repeat (2 * TBL_DEPTH + 8) @(posedge clk_i);
    if (pending.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending.size()));

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
